@@ hw/rtl/dwpi_pkg.sv @@
// ----------------------------------------------------------------------------
// dwpi_pkg
// shared widths, register indexes, reset values and limits for the
// differential wheel pi controller
// ----------------------------------------------------------------------------
`default_nettype none

package dwpi_pkg;

    // default fixed point and integrator sizing
    localparam int FRAC_BITS_DEF = 16;
    localparam int SUM_WIDTH_DEF = 32;

    // field widths
    localparam int IN_W       = 11;
    localparam int DUTY_W     = 7;
    localparam int CORR_W     = 8;
    localparam int GAIN_W     = 8;
    localparam int WEIGHT_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    // register indexes
    localparam cfg_index_t CFG_PROP_GAIN       = 2'd0;
    localparam cfg_index_t CFG_INTEGRAL_WEIGHT = 2'd1;
    localparam cfg_index_t CFG_BIAS_GAIN       = 2'd2;

    // register reset values
    localparam logic [GAIN_W-1:0]   PROP_GAIN_RST       = 8'd5;
    localparam logic [WEIGHT_W-1:0] INTEGRAL_WEIGHT_RST = 16'd21845;
    localparam logic [WEIGHT_W-1:0] BIAS_GAIN_RST       = 16'd3277;

    // limits
    localparam int SPEED_MAX = 100;
    localparam int BIAS_MAX  = 100;
    localparam int DUTY_MAX  = 100;
    localparam int CORR_MAX  = 100;

endpackage

`default_nettype wire

@@ hw/rtl/differential_wheel_pi_controller.sv @@
// ----------------------------------------------------------------------------
// differential_wheel_pi_controller
// steering correction by trapezoid integral of the bias error, then one pi
// stage per wheel, all on one shared multiplier under a small sequencer
// ----------------------------------------------------------------------------
// a request passes through the bias, corr, err, sum, wl, wr, gl and gr states
//   and is registered in done once the output register is free; in_ready low
//   while the sequencer runs; the single shared multiplier is used five times per request
// a finished result waits in the output register while the next request runs
// reset: clears the correction, previous bias error and both integrators,
//   loads the register defaults; no clearing pass
`default_nettype none

module differential_wheel_pi_controller #(
    parameter int FRAC_BITS = dwpi_pkg::FRAC_BITS_DEF,
    parameter int SUM_WIDTH = dwpi_pkg::SUM_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              cfg_write,
    input  wire dwpi_pkg::cfg_index_t              cfg_index,
    input  wire logic [dwpi_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [dwpi_pkg::IN_W-1:0]  left_speed,
    input  wire logic signed [dwpi_pkg::IN_W-1:0]  right_speed,
    input  wire logic signed [dwpi_pkg::IN_W-1:0]  target_speed,
    input  wire logic signed [dwpi_pkg::IN_W-1:0]  steer_bias,

    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [dwpi_pkg::DUTY_W-1:0]            right_duty,
    output logic [dwpi_pkg::DUTY_W-1:0]            left_duty,
    output logic signed [dwpi_pkg::CORR_W-1:0]     steer_correction
);

    localparam int IW  = dwpi_pkg::IN_W;
    localparam int DW  = dwpi_pkg::DUTY_W;
    localparam int OCW = dwpi_pkg::CORR_W;
    localparam int EBW = IW + 2;
    localparam int BSW = IW + 3;
    localparam int DFW = IW + 1;
    localparam int EW  = FRAC_BITS + 17;
    localparam int UBW = FRAC_BITS + 16;
    localparam int CW  = FRAC_BITS + 8;
    localparam int AW  = ((SUM_WIDTH > EW) ? SUM_WIDTH : EW) + 1;
    localparam int MBW = dwpi_pkg::WEIGHT_W + 1;
    localparam int PW  = AW + MBW;
    localparam int BPW = 31;
    localparam int UP  = (FRAC_BITS > 16) ? (FRAC_BITS - 16) : 0;
    localparam int DN  = (FRAC_BITS < 16) ? (16 - FRAC_BITS) : 0;
    localparam int QW  = BPW + UP;

    localparam logic signed [IW-1:0]  SPEED_HI = IW'(dwpi_pkg::SPEED_MAX);
    localparam logic signed [IW-1:0]  BIAS_HI  = IW'(dwpi_pkg::BIAS_MAX);
    localparam logic signed [IW-1:0]  BIAS_LO  = -IW'(dwpi_pkg::BIAS_MAX);
    localparam logic signed [PW-1:0]  DUTY_TOP = PW'(dwpi_pkg::DUTY_MAX) <<< FRAC_BITS;
    localparam logic signed [UBW-1:0] CORR_HI  = UBW'(dwpi_pkg::CORR_MAX) <<< FRAC_BITS;
    localparam logic signed [UBW-1:0] CORR_LO  = -CORR_HI;
    localparam logic signed [CW-1:0]  ACC_HI   = CW'(dwpi_pkg::CORR_MAX) <<< FRAC_BITS;
    localparam logic signed [CW-1:0]  ACC_LO   = -ACC_HI;
    localparam logic signed [AW-1:0]  SUM_MAX  = (AW'(1) <<< (SUM_WIDTH - 1)) - AW'(1);
    localparam logic signed [AW-1:0]  SUM_MIN  = -SUM_MAX - AW'(1);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_BIAS = 4'd1;
    localparam logic [3:0] ST_CORR = 4'd2;
    localparam logic [3:0] ST_ERR  = 4'd3;
    localparam logic [3:0] ST_SUM  = 4'd4;
    localparam logic [3:0] ST_WL   = 4'd5;
    localparam logic [3:0] ST_WR   = 4'd6;
    localparam logic [3:0] ST_GL   = 4'd7;
    localparam logic [3:0] ST_GR   = 4'd8;
    localparam logic [3:0] ST_DONE = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    logic [dwpi_pkg::GAIN_W-1:0]   gain_reg, gain_next;
    logic [dwpi_pkg::WEIGHT_W-1:0] weight_reg, weight_next;
    logic [dwpi_pkg::WEIGHT_W-1:0] bgain_reg, bgain_next;

    logic signed [CW-1:0]        accum_reg, accum_next;
    logic signed [EBW-1:0]       prev_reg, prev_next;
    logic signed [SUM_WIDTH-1:0] lsum_reg, lsum_next;
    logic signed [SUM_WIDTH-1:0] rsum_reg, rsum_next;

    logic signed [DFW-1:0] ldif_reg, ldif_next;
    logic signed [DFW-1:0] rdif_reg, rdif_next;
    logic signed [EBW-1:0] eb_reg, eb_next;
    logic signed [BSW-1:0] bsum_reg, bsum_next;
    logic signed [PW-1:0]  prod_reg, prod_next;
    logic signed [UBW-1:0] ub_reg, ub_next;
    logic signed [EW-1:0]  el_reg, el_next;
    logic signed [EW-1:0]  er_reg, er_next;
    logic signed [AW-1:0]  pil_reg, pil_next;
    logic signed [AW-1:0]  pir_reg, pir_next;
    logic signed [OCW-1:0] corr_reg, corr_next;
    logic [DW-1:0]         ldty_reg, ldty_next;

    logic [DW-1:0]         rduty_out_reg, rduty_out_next;
    logic [DW-1:0]         lduty_out_reg, lduty_out_next;
    logic signed [OCW-1:0] corr_out_reg, corr_out_next;

    logic signed [AW-1:0]  mul_a;
    logic signed [MBW-1:0] mul_b;
    logic signed [PW-1:0]  mul_p;

    logic                  in_fire;
    logic signed [IW-1:0]  tgt_c;
    logic signed [IW-1:0]  bias_c;
    logic signed [EBW-1:0] eb_c;
    logic signed [UBW-1:0] bias_step;
    logic signed [AW-1:0]  lsum_w;
    logic signed [AW-1:0]  rsum_w;

    function automatic logic [DW-1:0] duty_clamp(input logic signed [PW-1:0] u);
        logic [DW-1:0] d;
        if (u < 0)
            d = '0;
        else if (u > DUTY_TOP)
            d = DW'(dwpi_pkg::DUTY_MAX);
        else
            d = DW'(u >>> FRAC_BITS);
        return d;
    endfunction

    function automatic logic signed [SUM_WIDTH-1:0] sat_sum(input logic signed [AW-1:0] x);
        logic signed [SUM_WIDTH-1:0] s;
        if (x > SUM_MAX)
            s = SUM_WIDTH'(SUM_MAX);
        else if (x < SUM_MIN)
            s = SUM_WIDTH'(SUM_MIN);
        else
            s = SUM_WIDTH'(x);
        return s;
    endfunction

    // shared multiplier
    assign mul_p = mul_a * mul_b;

    assign in_ready         = (state_reg == ST_IDLE);
    assign in_fire          = in_valid && in_ready;
    assign out_valid        = out_valid_reg;
    assign right_duty       = rduty_out_reg;
    assign left_duty        = lduty_out_reg;
    assign steer_correction = corr_out_reg;

    always_comb
    begin
        tgt_c     = (target_speed > SPEED_HI) ? SPEED_HI : target_speed;
        bias_c    = (steer_bias > BIAS_HI) ? BIAS_HI :
                    (steer_bias < BIAS_LO) ? BIAS_LO : steer_bias;
        eb_c      = EBW'(left_speed) - EBW'(right_speed) + EBW'(bias_c);
        // q16 trapezoid step moved to the working fraction
        bias_step = UBW'((QW'($signed(prod_reg[BPW-1:0])) <<< UP) >>> DN);
        lsum_w    = AW'(lsum_reg) + AW'(el_reg);
        rsum_w    = AW'(rsum_reg) + AW'(er_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        gain_next      = gain_reg;
        weight_next    = weight_reg;
        bgain_next     = bgain_reg;
        accum_next     = accum_reg;
        prev_next      = prev_reg;
        lsum_next      = lsum_reg;
        rsum_next      = rsum_reg;
        ldif_next      = ldif_reg;
        rdif_next      = rdif_reg;
        eb_next        = eb_reg;
        bsum_next      = bsum_reg;
        prod_next      = prod_reg;
        ub_next        = ub_reg;
        el_next        = el_reg;
        er_next        = er_reg;
        pil_next       = pil_reg;
        pir_next       = pir_reg;
        corr_next      = corr_reg;
        ldty_next      = ldty_reg;
        rduty_out_next = rduty_out_reg;
        lduty_out_next = lduty_out_reg;
        corr_out_next  = corr_out_reg;
        mul_a          = '0;
        mul_b          = '0;

        if (cfg_write)
        begin
            case (cfg_index)
                dwpi_pkg::CFG_PROP_GAIN:       gain_next   = cfg_data[dwpi_pkg::GAIN_W-1:0];
                dwpi_pkg::CFG_INTEGRAL_WEIGHT: weight_next = cfg_data[dwpi_pkg::WEIGHT_W-1:0];
                dwpi_pkg::CFG_BIAS_GAIN:       bgain_next  = cfg_data[dwpi_pkg::WEIGHT_W-1:0];
                default:                       ;
            endcase
        end

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    ldif_next  = DFW'(tgt_c) - DFW'(left_speed);
                    rdif_next  = DFW'(tgt_c) - DFW'(right_speed);
                    eb_next    = eb_c;
                    bsum_next  = BSW'(eb_c) + BSW'(prev_reg);
                    state_next = ST_BIAS;
                end
            end
            ST_BIAS:
            begin
                mul_a      = AW'(bsum_reg);
                mul_b      = $signed({1'b0, bgain_reg});
                prod_next  = mul_p;
                state_next = ST_CORR;
            end
            ST_CORR:
            begin
                ub_next    = UBW'(accum_reg) + bias_step;
                state_next = ST_ERR;
            end
            ST_ERR:
            begin
                // wheel errors use the correction before its clamp
                el_next    = (EW'(ldif_reg) <<< FRAC_BITS) - EW'(ub_reg);
                er_next    = (EW'(rdif_reg) <<< FRAC_BITS) + EW'(ub_reg);
                accum_next = (ub_reg > CORR_HI) ? ACC_HI :
                             (ub_reg < CORR_LO) ? ACC_LO : CW'(ub_reg);
                prev_next  = eb_reg;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                lsum_next  = sat_sum(lsum_w);
                rsum_next  = sat_sum(rsum_w);
                // integer part, truncated toward zero
                corr_next  = OCW'(accum_reg >>> FRAC_BITS) +
                             {{(OCW-1){1'b0}},
                              accum_reg[CW-1] && (accum_reg[FRAC_BITS-1:0] != '0)};
                state_next = ST_WL;
            end
            ST_WL:
            begin
                mul_a      = AW'(lsum_reg);
                mul_b      = $signed({1'b0, weight_reg});
                prod_next  = mul_p;
                state_next = ST_WR;
            end
            ST_WR:
            begin
                mul_a      = AW'(rsum_reg);
                mul_b      = $signed({1'b0, weight_reg});
                prod_next  = mul_p;
                pil_next   = AW'(el_reg) + AW'(prod_reg >>> dwpi_pkg::WEIGHT_W);
                state_next = ST_GL;
            end
            ST_GL:
            begin
                mul_a      = pil_reg;
                mul_b      = $signed({{(MBW-dwpi_pkg::GAIN_W){1'b0}}, gain_reg});
                prod_next  = mul_p;
                pir_next   = AW'(er_reg) + AW'(prod_reg >>> dwpi_pkg::WEIGHT_W);
                state_next = ST_GR;
            end
            ST_GR:
            begin
                mul_a      = pir_reg;
                mul_b      = $signed({{(MBW-dwpi_pkg::GAIN_W){1'b0}}, gain_reg});
                prod_next  = mul_p;
                ldty_next  = duty_clamp(prod_reg);
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    rduty_out_next = duty_clamp(prod_reg);
                    lduty_out_next = ldty_reg;
                    corr_out_next  = corr_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            gain_reg      <= dwpi_pkg::PROP_GAIN_RST;
            weight_reg    <= dwpi_pkg::INTEGRAL_WEIGHT_RST;
            bgain_reg     <= dwpi_pkg::BIAS_GAIN_RST;
            accum_reg     <= '0;
            prev_reg      <= '0;
            lsum_reg      <= '0;
            rsum_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            gain_reg      <= gain_next;
            weight_reg    <= weight_next;
            bgain_reg     <= bgain_next;
            accum_reg     <= accum_next;
            prev_reg      <= prev_next;
            lsum_reg      <= lsum_next;
            rsum_reg      <= rsum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ldif_reg      <= ldif_next;
        rdif_reg      <= rdif_next;
        eb_reg        <= eb_next;
        bsum_reg      <= bsum_next;
        prod_reg      <= prod_next;
        ub_reg        <= ub_next;
        el_reg        <= el_next;
        er_reg        <= er_next;
        pil_reg       <= pil_next;
        pir_reg       <= pir_next;
        corr_reg      <= corr_next;
        ldty_reg      <= ldty_next;
        rduty_out_reg <= rduty_out_next;
        lduty_out_reg <= lduty_out_next;
        corr_out_reg  <= corr_out_next;
    end

    // sequencer leaves idle on an accepted request
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == ST_BIAS && !in_ready))
        else $error("accepted request did not start the sequencer");

    // stored correction stays within its clamp
    a_accum_range: assert property (@(posedge clk) disable iff (!rst_n)
        (accum_reg <= ACC_HI) && (accum_reg >= ACC_LO))
        else $error("correction accumulator out of range");

    // delivered duties are clamped
    a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (rduty_out_reg <= DW'(dwpi_pkg::DUTY_MAX) &&
                           lduty_out_reg <= DW'(dwpi_pkg::DUTY_MAX)))
        else $error("duty out of range");

endmodule

`default_nettype wire

@@ tb/differential_wheel_pi_controller_checker.sv @@
// ----------------------------------------------------------------------------
// differential_wheel_pi_controller_checker
// watches the config port and both request channels, keeps its own copy of
// the registers, the steering integral and both wheel integrators, predicts
// the duty and correction of every accepted request and compares each
// accepted output against the oldest prediction
// ----------------------------------------------------------------------------
module differential_wheel_pi_controller_checker
    import dwpi_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int SUM_WIDTH = SUM_WIDTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  cfg_index_t                  cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  logic signed [IN_W-1:0]      left_speed,
    input  logic signed [IN_W-1:0]      right_speed,
    input  logic signed [IN_W-1:0]      target_speed,
    input  logic signed [IN_W-1:0]      steer_bias,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  logic [DUTY_W-1:0]           right_duty,
    input  logic [DUTY_W-1:0]           left_duty,
    input  logic signed [CORR_W-1:0]    steer_correction,
    output int                          mismatches,
    output int                          pending,
    output int                          checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE     = longint'(1) <<< FRAC_BITS;
    localparam longint SUM_LIM = longint'(1) <<< (SUM_WIDTH - 1);
    localparam int     ACC_W   = FRAC_BITS + 8;
    localparam int     BERR_W  = 13;

    typedef struct packed {
        logic [DUTY_W-1:0]        right_duty;
        logic [DUTY_W-1:0]        left_duty;
        logic signed [CORR_W-1:0] steer_correction;
    } wheel_cmd_t;

    logic [GAIN_W-1:0]            prop_gain;
    logic [WEIGHT_W-1:0]          integral_weight;
    logic [WEIGHT_W-1:0]          bias_gain;
    logic signed [ACC_W-1:0]      correction;
    logic signed [BERR_W-1:0]     last_bias_error;
    logic signed [SUM_WIDTH-1:0]  left_sum;
    logic signed [SUM_WIDTH-1:0]  right_sum;
    wheel_cmd_t                   predicted_cmds[$];

    function automatic longint limit(input longint x, input longint lo, input longint hi);
        if (x < lo)
            return lo;
        if (x > hi)
            return hi;
        return x;
    endfunction

    function automatic longint q16_to_frac(input longint x);
        if (FRAC_BITS >= 16)
            return x <<< (FRAC_BITS - 16);
        return x >>> (16 - FRAC_BITS);
    endfunction

    function automatic logic [DUTY_W-1:0] duty_from(input longint err, input longint acc);
        longint u;
        u = longint'(prop_gain) * (err + ((acc * longint'(integral_weight)) >>> 16));
        u = limit(u, longint'(0), longint'(DUTY_MAX) * ONE);
        return DUTY_W'(u >>> FRAC_BITS);
    endfunction

    task automatic flag_mismatch(input string msg);
        if (mismatches < 100)
            $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic predict_sample(input longint l, input longint r, input longint t,
                                  input longint b);
        longint     bias;
        longint     tgt;
        longint     eb;
        longint     ub;
        longint     el;
        longint     er;
        longint     lsum;
        longint     rsum;
        longint     stored;
        longint     corr;
        wheel_cmd_t cmd;
        bias = limit(b, -longint'(BIAS_MAX), longint'(BIAS_MAX));
        tgt  = (t > longint'(SPEED_MAX)) ? longint'(SPEED_MAX) : t;
        eb   = l - r + bias;
        // correction used this sample is the one before its clamp
        ub   = longint'(correction) +
               q16_to_frac((eb + longint'(last_bias_error)) * longint'(bias_gain));
        el   = (tgt - l) * ONE - ub;
        er   = (tgt - r) * ONE + ub;
        lsum = limit(longint'(left_sum) + el, -SUM_LIM, SUM_LIM - 1);
        rsum = limit(longint'(right_sum) + er, -SUM_LIM, SUM_LIM - 1);
        left_sum  = SUM_WIDTH'(lsum);
        right_sum = SUM_WIDTH'(rsum);
        cmd.left_duty  = duty_from(el, lsum);
        cmd.right_duty = duty_from(er, rsum);
        stored = limit(ub, -longint'(CORR_MAX) * ONE, longint'(CORR_MAX) * ONE);
        correction      = ACC_W'(stored);
        last_bias_error = BERR_W'(eb);
        corr = (stored >= 0) ? (stored >>> FRAC_BITS) : -((-stored) >>> FRAC_BITS);
        cmd.steer_correction = CORR_W'(corr);
        predicted_cmds.push_back(cmd);
    endtask

    task automatic check_output();
        wheel_cmd_t want;
        if (predicted_cmds.size() == 0)
        begin
            flag_mismatch($sformatf("output %0d/%0d/%0d with no request pending",
                                    right_duty, left_duty, steer_correction));
        end
        else
        begin
            want = predicted_cmds.pop_front();
            if (right_duty !== want.right_duty)
                flag_mismatch($sformatf("right_duty expected %0d got %0d",
                                        want.right_duty, right_duty));
            if (left_duty !== want.left_duty)
                flag_mismatch($sformatf("left_duty expected %0d got %0d",
                                        want.left_duty, left_duty));
            if (steer_correction !== want.steer_correction)
                flag_mismatch($sformatf("steer_correction expected %0d got %0d",
                                        want.steer_correction, steer_correction));
            checked++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain       = PROP_GAIN_RST;
            integral_weight = INTEGRAL_WEIGHT_RST;
            bias_gain       = BIAS_GAIN_RST;
            correction      = '0;
            last_bias_error = '0;
            left_sum        = '0;
            right_sum       = '0;
            predicted_cmds.delete();
            pending         = 0;
            mismatches      = 0;
            checked         = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_output();
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_PROP_GAIN:       prop_gain       = cfg_data[GAIN_W-1:0];
                    CFG_INTEGRAL_WEIGHT: integral_weight = cfg_data[WEIGHT_W-1:0];
                    CFG_BIAS_GAIN:       bias_gain       = cfg_data[WEIGHT_W-1:0];
                    default:             ;
                endcase
            end
            if (in_valid && in_ready)
                predict_sample(longint'(left_speed), longint'(right_speed),
                               longint'(target_speed), longint'(steer_bias));
            pending = predicted_cmds.size();
        end
    end

endmodule

@@ tb/differential_wheel_pi_controller_tb.sv @@
// ----------------------------------------------------------------------------
// differential_wheel_pi_controller_tb
// drives wheel speed requests through the controller under several register
// settings and random idling on both channels, including one long output
// hold-off; the checker predicts and compares every output
// ----------------------------------------------------------------------------
module differential_wheel_pi_controller_tb import dwpi_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam cfg_index_t CFG_UNUSED  = 2'd3;
    localparam int         HOLD_CYCLES = 300;
    localparam int         CYCLE_LIMIT = 200_000;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_write;
    cfg_index_t               cfg_index;
    logic [CFG_DATA_W-1:0]    cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    logic signed [IN_W-1:0]   left_speed;
    logic signed [IN_W-1:0]   right_speed;
    logic signed [IN_W-1:0]   target_speed;
    logic signed [IN_W-1:0]   steer_bias;
    logic                     out_valid;
    logic                     out_ready;
    logic [DUTY_W-1:0]        right_duty;
    logic [DUTY_W-1:0]        left_duty;
    logic signed [CORR_W-1:0] steer_correction;

    int mismatches;
    int pending;
    int checked;
    int samples_sent = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycles = 0;
    bit hold_req = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    differential_wheel_pi_controller dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .left_speed       (left_speed),
        .right_speed      (right_speed),
        .target_speed     (target_speed),
        .steer_bias       (steer_bias),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .right_duty       (right_duty),
        .left_duty        (left_duty),
        .steer_correction (steer_correction)
    );

    differential_wheel_pi_controller_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .left_speed       (left_speed),
        .right_speed      (right_speed),
        .target_speed     (target_speed),
        .steer_bias       (steer_bias),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .right_duty       (right_duty),
        .left_duty        (left_duty),
        .steer_correction (steer_correction),
        .mismatches       (mismatches),
        .pending          (pending),
        .checked          (checked)
    );

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    // receiver side, with one long hold-off on request
    initial
    begin
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_sample(input int l, input int r, input int t, input int b);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        left_speed   <= IN_W'(l);
        right_speed  <= IN_W'(r);
        target_speed <= IN_W'(t);
        steer_bias   <= IN_W'(b);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        samples_sent++;
    endtask

    function automatic int corner_value();
        case ($urandom_range(3))
            0:       return -1024;
            1:       return 1023;
            2:       return 100;
            default: return -100;
        endcase
    endfunction

    task automatic random_samples(input int count);
        int kind;
        int t;
        repeat (count)
        begin
            kind = $urandom_range(99);
            if (kind < 55)
            begin
                t = $urandom_range(140) - 20;
                send_sample(t + $urandom_range(60) - 30, t + $urandom_range(60) - 30, t,
                            $urandom_range(300) - 150);
            end
            else if (kind < 85)
            begin
                send_sample($urandom, $urandom, $urandom, $urandom);
            end
            else
            begin
                send_sample(corner_value(), corner_value(), corner_value(), corner_value());
            end
        end
    endtask

    task automatic write_reg(input cfg_index_t idx, input int unsigned value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    // drop valid, wait for every output, then let the pipeline drain
    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (12) @(posedge clk);
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        cfg_write    <= 1'b0;
        cfg_index    <= CFG_PROP_GAIN;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        left_speed   <= '0;
        right_speed  <= '0;
        target_speed <= '0;
        steer_bias   <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 26;
        recv_idle_pct = 50;
        send_sample(0, 0, 0, 0);
        send_sample(1023, 1023, 1023, 1023);
        send_sample(-1024, -1024, -1024, -1024);
        send_sample(0, 0, 100, 0);
        send_sample(0, 0, 101, 0);
        send_sample(0, 0, -1024, 0);
        send_sample(10, 10, 50, 100);
        send_sample(50, 50, 50, 101);
        send_sample(20, 20, 50, -100);
        send_sample(20, 20, 50, -101);
        // steering integral driven past its clamp both ways
        repeat (3) send_sample(1023, -1024, 100, 1023);
        repeat (3) send_sample(-1024, 1023, 100, -1024);
        // duty above full scale, then below zero
        repeat (4) send_sample(-1024, -1024, 100, 0);
        repeat (4) send_sample(1023, 1023, -1024, 0);
        random_samples(350);
        settle();

        write_reg(CFG_PROP_GAIN, 255);
        write_reg(CFG_INTEGRAL_WEIGHT, 65535);
        write_reg(CFG_BIAS_GAIN, 65535);
        send_idle_pct = 50;
        recv_idle_pct = 26;
        hold_req = 1'b1;
        random_samples(350);
        settle();

        write_reg(CFG_PROP_GAIN, 0);
        write_reg(CFG_INTEGRAL_WEIGHT, 0);
        write_reg(CFG_BIAS_GAIN, 0);
        write_reg(CFG_UNUSED, $urandom);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_samples(150);
        settle();

        write_reg(CFG_PROP_GAIN, $urandom_range(1, 40));
        write_reg(CFG_INTEGRAL_WEIGHT, $urandom_range(65535));
        write_reg(CFG_BIAS_GAIN, $urandom_range(65535));
        random_samples(275);
        settle();

        write_reg(CFG_PROP_GAIN, 1);
        write_reg(CFG_INTEGRAL_WEIGHT, INTEGRAL_WEIGHT_RST);
        write_reg(CFG_BIAS_GAIN, $urandom_range(1, 8000));
        random_samples(275);
        settle();

        $display("sent %0d speed requests over five register settings, %0d outputs checked",
                 samples_sent, checked);
        $display("idling on both sides, one %0d cycle output hold-off, %0d mismatches",
                 HOLD_CYCLES, mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
